FILE: rtl/koc_pkg.sv
// Package for the keyword occurrence counter: item modes, register indexes,
// default sizes and the command record passed from front to back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package koc_pkg;
	localparam int unsigned MaxWordsDef   = 512;
	localparam int unsigned MaxWordLenDef = 16;
	localparam int unsigned ChunkLenDef   = 999;

	localparam int unsigned ThreshW = 16;
	localparam int unsigned WiuW    = 10;
	localparam int unsigned SlotW   = 9;
	localparam int unsigned PosW    = 4;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned CfgDataW = 16;

	localparam logic [ThreshW-1:0] ThreshReset = 16'd4;
	localparam logic [WiuW-1:0]    WiuReset    = 10'd300;

	typedef enum logic [1:0] {
		MODE_LOAD = 2'd0,
		MODE_TEXT = 2'd1,
		MODE_END  = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	localparam logic [CfgIdxW-1:0] REG_THRESH = 1'b0;
	localparam logic [CfgIdxW-1:0] REG_WIU    = 1'b1;

	// One queued command: dictionary loads, text bytes and end-of-text all
	// reach the back end in arrival order.
	typedef struct packed {
		mode_t            kind;
		logic [SlotW-1:0] slot;
		logic [PosW-1:0]  pos;
		logic [7:0]       data;
		logic             last;
	} cmd_t;
endpackage
`default_nettype wire

FILE: rtl/koc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module koc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/koc_front.sv
// Front end: accepts input beats, drops unused beats and out-of-range loads,
// and queues loads, text and end-of-text commands. Uses koc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module koc_front #(
	parameter int unsigned MAX_WORDS    = koc_pkg::MaxWordsDef,
	parameter int unsigned MAX_WORD_LEN = koc_pkg::MaxWordLenDef
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [1:0]                     mode,
	input  wire logic [koc_pkg::SlotW-1:0]      slot,
	input  wire logic [koc_pkg::PosW-1:0]       position,
	input  wire logic [7:0]                     byte_value,
	input  wire logic                           last_char,
	// Command queue toward the back end.
	output logic                                cmd_valid,
	output koc_pkg::cmd_t                       cmd,
	input  wire logic                           cmd_take
);
	import koc_pkg::*;
	localparam int unsigned QD = 2;

	cmd_t       q_q [QD];
	logic [0:0] wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       acc, in_range, enq;
	mode_t      m;

	assign m = mode_t'(mode);
	assign full = (cnt_q == 2'(QD));
	assign acc = push && !full;
	assign in_range = (32'(slot) < MAX_WORDS) && (32'(position) < MAX_WORD_LEN);

	// Loads travel through the queue so they never overtake pending text.
	assign enq = acc && (m == MODE_TEXT || m == MODE_END || (m == MODE_LOAD && in_range));

	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_q[rd_q];

	// Two-entry command queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) wr_q <= wr_q + 1'b1;
			if (cmd_take) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + 2'(enq) - 2'(cmd_take);
		end
	end

	always_ff @(posedge clk) begin
		if (enq) q_q[wr_q] <= '{kind: m, slot: slot, pos: position,
			data: byte_value, last: last_char};
	end
endmodule
`default_nettype wire

FILE: rtl/koc_back.sv
// Back end: writes dictionary loads, shifts text bytes into the chunk history,
// sweeps the dictionary one word a cycle, counts matches and emits totals.
// Uses koc_pkg, koc_ram.
`timescale 1ns / 1ps
`default_nettype none
module koc_back #(
	parameter int unsigned MAX_WORDS    = koc_pkg::MaxWordsDef,
	parameter int unsigned MAX_WORD_LEN = koc_pkg::MaxWordLenDef,
	parameter int unsigned CHUNK_LEN    = koc_pkg::ChunkLenDef
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cmd_valid,
	input  koc_pkg::cmd_t                       cmd,
	output logic                                cmd_take,
	input  wire logic [koc_pkg::ThreshW-1:0]    thresh,
	input  wire logic [koc_pkg::WiuW-1:0]       wiu,
	output logic                                empty,
	input  wire logic                           pop,
	output logic [31:0]                         total_matches,
	output logic                                class_hit,
	output logic                                count_saturated
);
	import koc_pkg::*;
	localparam int unsigned SW = $clog2(MAX_WORDS);
	localparam int unsigned PW = $clog2(MAX_WORD_LEN);
	localparam int unsigned LW = $clog2(MAX_WORD_LEN+1);
	localparam int unsigned CW = $clog2(CHUNK_LEN+1);
	localparam int unsigned NW = $clog2(MAX_WORDS+1);
	localparam int unsigned RowW = 8*MAX_WORD_LEN;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_LAST} state_t;

	state_t           state_q;
	logic [7:0]       hist_q [MAX_WORD_LEN];
	logic [LW-1:0]    fill_q;
	logic [CW-1:0]    cpos_q;
	logic [31:0]      total_q;
	logic             sat_q;
	logic [NW-1:0]    limit_q, idx_q;
	logic             chunk_end_q;
	logic             rd_valid_s1;
	logic [RowW-1:0]  row;
	logic [LW-1:0]    len_rd;
	logic [SW-1:0]    raddr;
	logic             hit;
	logic             out_full_q;
	logic [NW-1:0]    wiu_sat;
	logic             ld_take;
	logic [SW-1:0]    ld_slot;
	logic [PW-1:0]    ld_pos;

	assign raddr = SW'(idx_q);
	assign wiu_sat = (32'(wiu) > MAX_WORDS) ? NW'(MAX_WORDS) : NW'(wiu);

	// Dictionary loads are written when the sequencer takes them.
	assign ld_take = cmd_take && (cmd.kind == MODE_LOAD);
	assign ld_slot = SW'(cmd.slot);
	assign ld_pos  = PW'(cmd.pos);

	// One RAM per character column, so all characters of a word are read together.
	for (genvar k = 0; k < MAX_WORD_LEN; k++) begin : g_col
		koc_ram #(.WIDTH(8), .DEPTH(MAX_WORDS)) u_chr (
			.clk(clk),
			.we(ld_take && (ld_pos == PW'(k))),
			.waddr(ld_slot),
			.wdata(cmd.data),
			.raddr(raddr),
			.rdata(row[8*k +: 8])
		);
	end
	koc_ram #(.WIDTH(LW), .DEPTH(MAX_WORDS)) u_len (
		.clk(clk), .we(ld_take && cmd.last), .waddr(ld_slot),
		.wdata(LW'(ld_pos) + LW'(1)),
		.raddr(raddr), .rdata(len_rd)
	);

	// Word compare: char k must equal history byte len-1-k.
	always_comb begin
		logic ok;
		ok = (len_rd != '0) && (len_rd <= fill_q) && (32'(len_rd) <= MAX_WORD_LEN);
		for (int k = 0; k < MAX_WORD_LEN; k++) begin
			if (LW'(k) < len_rd) begin
				if (row[8*k +: 8] != hist_q[PW'(len_rd - LW'(1) - LW'(k))]) ok = 1'b0;
			end
		end
		hit = ok;
	end

	assign cmd_take = cmd_valid && (state_q == ST_IDLE) &&
		!((cmd.kind == MODE_END) && out_full_q);
	assign empty = !out_full_q;

	// Sequencer, history, total and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			for (int k = 0; k < MAX_WORD_LEN; k++) hist_q[k] <= '0;
			fill_q      <= '0;
			cpos_q      <= '0;
			total_q     <= '0;
			sat_q       <= 1'b0;
			limit_q     <= '0;
			idx_q       <= '0;
			chunk_end_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
			out_full_q  <= 1'b0;
			total_matches   <= '0;
			class_hit       <= 1'b0;
			count_saturated <= 1'b0;
		end else begin
			if (pop && out_full_q) out_full_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
			// Count a hit from the word read last cycle.
			if (rd_valid_s1 && hit) begin
				if (total_q == '1) sat_q <= 1'b1;
				else total_q <= total_q + 32'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					// A load needs nothing beyond its memory write.
					if (cmd_take) begin
						if (cmd.kind == MODE_END) begin
							out_full_q      <= 1'b1;
							total_matches   <= total_q;
							class_hit       <= (total_q >= 32'(thresh));
							count_saturated <= sat_q;
							total_q <= '0;
							sat_q   <= 1'b0;
							for (int k = 0; k < MAX_WORD_LEN; k++) hist_q[k] <= '0;
							fill_q <= '0;
							cpos_q <= '0;
						end else if (cmd.kind == MODE_TEXT) begin
							for (int k = MAX_WORD_LEN-1; k > 0; k--) hist_q[k] <= hist_q[k-1];
							hist_q[0] <= cmd.data;
							if (32'(fill_q) < MAX_WORD_LEN) fill_q <= fill_q + LW'(1);
							cpos_q <= cpos_q + CW'(1);
							chunk_end_q <= (cmd.data == 8'h0A) ||
								(32'(cpos_q) + 1 >= CHUNK_LEN);
							limit_q <= wiu_sat;
							idx_q   <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (idx_q < limit_q) begin
						rd_valid_s1 <= 1'b1;
						idx_q <= idx_q + NW'(1);
					end else begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					// The final hit has already been counted; now close the chunk.
					if (chunk_end_q) begin
						for (int k = 0; k < MAX_WORD_LEN; k++) hist_q[k] <= '0;
						fill_q <= '0;
						cpos_q <= '0;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: rtl/keyword_occurrence_counter.sv
// Top level of the keyword occurrence counter: configuration registers,
// front end and back end. Uses koc_pkg, koc_front, koc_back.
//
// Usage: the input side is a queue (push/full). Mode 0 beats load one
// dictionary character, mode 1 beats are text bytes, mode 2 ends the text
// and yields one result; mode 3 is dropped at the input.
// The result side is a queue (empty/pop) holding one total at a time.
// All kept beats pass in order through a two-beat command queue, so a load
// never overtakes text that is still waiting.
// In the back end each text byte sweeps min(words_in_use, MAX_WORDS) words:
// the dictionary is swept one word a cycle through a registered memory read.
// A load is only a memory write in the back end. An end-of-text result is
// registered once the back end is idle and the result register is free.
// Reset clears totals, history and the queue; dictionary contents stay
// undefined until loaded. While a result waits unpopped, a later end-of-text
// stalls in the queue and full rises once it fills.
// Configuration: cfg_we, cfg_idx, cfg_data write one register per cycle.
`timescale 1ns / 1ps
`default_nettype none
module keyword_occurrence_counter #(
	parameter int unsigned MAX_WORDS    = koc_pkg::MaxWordsDef,
	parameter int unsigned MAX_WORD_LEN = koc_pkg::MaxWordLenDef,
	parameter int unsigned CHUNK_LEN    = koc_pkg::ChunkLenDef
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [koc_pkg::CfgIdxW-1:0]   cfg_idx,
	input  wire logic [koc_pkg::CfgDataW-1:0]  cfg_data,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [1:0]                    mode,
	input  wire logic [koc_pkg::SlotW-1:0]     slot,
	input  wire logic [koc_pkg::PosW-1:0]      position,
	input  wire logic [7:0]                    byte_value,
	input  wire logic                          last_char,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [31:0]                        total_matches,
	output logic                               class_hit,
	output logic                               count_saturated
);
	import koc_pkg::*;

	logic [ThreshW-1:0] thresh_q;
	logic [WiuW-1:0]    wiu_q;
	logic cmd_valid, cmd_take;
	cmd_t          cmd;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= ThreshReset;
			wiu_q    <= WiuReset;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_THRESH: thresh_q <= cfg_data;
				REG_WIU:    wiu_q    <= cfg_data[WiuW-1:0];
				default: ;
			endcase
		end
	end

	koc_front #(.MAX_WORDS(MAX_WORDS), .MAX_WORD_LEN(MAX_WORD_LEN)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .mode(mode),
		.slot(slot), .position(position), .byte_value(byte_value),
		.last_char(last_char), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
	);

	koc_back #(.MAX_WORDS(MAX_WORDS), .MAX_WORD_LEN(MAX_WORD_LEN),
		.CHUNK_LEN(CHUNK_LEN)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_take(cmd_take), .thresh(thresh_q), .wiu(wiu_q), .empty(empty),
		.pop(pop), .total_matches(total_matches), .class_hit(class_hit),
		.count_saturated(count_saturated)
	);
endmodule
`default_nettype wire

FILE: rtl/koc_checker.sv
// Port-level checker for the keyword occurrence counter, bound to the top.
// Uses koc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module koc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [31:0] total_matches,
	input wire logic        class_hit,
	input wire logic        count_saturated
);
	import koc_pkg::*;

	// A waiting result holds until popped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(total_matches)))
		else $error("result changed while waiting");

	// A saturated count reports the maximum total.
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && count_saturated) |-> (total_matches == 32'hFFFF_FFFF))
		else $error("saturated without max total");

	// The class bit of a waiting result holds until popped.
	a_cls: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(class_hit))
		else $error("class bit changed while waiting");
endmodule

bind keyword_occurrence_counter koc_checker u_koc_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.total_matches(total_matches), .class_hit(class_hit),
	.count_saturated(count_saturated)
);
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for keyword_occurrence_counter: loads dictionaries,
// streams text and compares every reported total with a built-in predictor.
// Depends on koc_pkg and the keyword_occurrence_counter RTL.
`timescale 1ns / 1ps
module tb;
	import koc_pkg::*;

	localparam int NumSlots = MaxWordsDef;
	localparam int WordLen  = MaxWordLenDef;
	localparam int ChunkLen = ChunkLenDef;

	typedef struct {
		logic [31:0] total;
		logic        hit;
		logic        sat;
	} tally_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_idx = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                push = 1'b0;
	logic                full;
	logic [1:0]          mode = MODE_NONE;
	logic [SlotW-1:0]    slot = '0;
	logic [PosW-1:0]     position = '0;
	logic [7:0]          byte_value = '0;
	logic                last_char = 1'b0;
	logic                empty;
	logic                pop = 1'b0;
	logic [31:0]         total_matches;
	logic                class_hit;
	logic                count_saturated;

	// Predictor state, a copy of what the block holds.
	logic [7:0]  dict_chr [NumSlots][WordLen];
	logic [15:0] chr_known [NumSlots];
	int          word_len [NumSlots];
	logic [7:0]  history [WordLen];
	int          hist_fill;
	int          chunk_pos;
	logic [31:0] match_total;
	logic        match_sat;
	logic [15:0] threshold;
	logic [9:0]  words_searched;

	tally_t pending_tallies [$];
	int     errors = 0;
	int     hold_off = 0;
	bit     no_gaps = 0;

	keyword_occurrence_counter DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .push(push), .full(full), .mode(mode), .slot(slot),
		.position(position), .byte_value(byte_value), .last_char(last_char),
		.empty(empty), .pop(pop), .total_matches(total_matches),
		.class_hit(class_hit), .count_saturated(count_saturated)
	);

	always #5 clk = ~clk;

	// Hard stop in case the handshake hangs.
	initial begin
		#50000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic void clear_chunk();
		for (int k = 0; k < WordLen; k++) history[k] = 8'h00;
		hist_fill = 0;
		chunk_pos = 0;
	endfunction

	function automatic bit word_found(int s);
		int n;
		n = word_len[s];
		if (n == 0 || n > hist_fill) return 0;
		for (int k = 0; k < n; k++)
			if (dict_chr[s][k] != history[n - 1 - k]) return 0;
		return 1;
	endfunction

	// Updates the predictor for one accepted beat.
	function automatic void predict_beat(logic [1:0] m, int s, int p, logic [7:0] b,
		logic l);
		int lim;
		tally_t t;
		case (m)
			MODE_LOAD: begin
				dict_chr[s][p] = b;
				chr_known[s][p] = 1'b1;
				if (l) word_len[s] = p + 1;
			end
			MODE_TEXT: begin
				lim = (words_searched > NumSlots) ? NumSlots : words_searched;
				for (int k = WordLen - 1; k > 0; k--) history[k] = history[k - 1];
				history[0] = b;
				if (hist_fill < WordLen) hist_fill++;
				chunk_pos++;
				for (int s2 = 0; s2 < lim; s2++)
					if (word_found(s2)) begin
						if (match_total == 32'hFFFF_FFFF) match_sat = 1'b1;
						else match_total++;
					end
				if (b == 8'h0A || chunk_pos >= ChunkLen) clear_chunk();
			end
			MODE_END: begin
				t.total = match_total;
				t.hit = (match_total >= threshold);
				t.sat = match_sat;
				pending_tallies.push_back(t);
				match_total = '0;
				match_sat = 1'b0;
				clear_chunk();
			end
			default: ;
		endcase
	endfunction

	function automatic int draw_gap();
		if (no_gaps) return 0;
		return $urandom_range(0, 13);
	endfunction

	// Offers one beat and returns once it has been accepted.
	task automatic send_beat(logic [1:0] m, int s = 0, int p = 0, logic [7:0] b = 0,
		logic l = 0);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode <= m;
		slot <= s;
		position <= p;
		byte_value <= b;
		last_char <= l;
		push <= 1'b1;
		do @(posedge clk); while (full);
		predict_beat(m, s, p, b, l);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_THRESH) threshold = data;
		else words_searched = data[9:0];
	endtask

	// Waits until every expected total has come and the back end has settled.
	task automatic drain();
		push <= 1'b0;
		while (pending_tallies.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic load_word(int s, int n, logic [7:0] c = 0, bit random_chars = 1);
		for (int p = 0; p < n; p++)
			send_beat(MODE_LOAD, s, p, random_chars ? text_char() : c, p == n - 1);
	endtask

	// Mostly a small alphabet so that words actually occur in the text.
	function automatic logic [7:0] text_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return "a" + $urandom_range(0, 2);
		if (r < 78) return 8'h0A;
		return $urandom_range(0, 255);
	endfunction

	// Every slot gets a valid one-character word so any search range is legal.
	task automatic test_fill_dictionary();
		no_gaps = 1;
		for (int s = 0; s < NumSlots; s++)
			send_beat(MODE_LOAD, s, 0, "a" + (s % 3), 1'b1);
		no_gaps = 0;
		drain();
	endtask

	task automatic test_directed();
		string txt;
		write_reg(REG_WIU, 10'd5);
		write_reg(REG_THRESH, 16'd0);
		send_beat(MODE_LOAD, 0, 0, "a");
		send_beat(MODE_LOAD, 0, 1, "b", 1'b1);
		send_beat(MODE_LOAD, 2, 0, 8'h00, 1'b1);
		send_beat(MODE_LOAD, 3, 0, 8'hFF, 1'b1);
		// Partial load: the length of slot 4 stays one.
		send_beat(MODE_LOAD, 4, 1, "c");
		drain();
		txt = "abab";
		foreach (txt[k]) send_beat(MODE_TEXT, 0, 0, txt[k]);
		send_beat(MODE_TEXT, 0, 0, 8'h0A);
		send_beat(MODE_TEXT, 0, 0, "b");
		send_beat(MODE_TEXT, 0, 0, 8'h00);
		send_beat(MODE_TEXT, 0, 0, 8'hFF);
		send_beat(MODE_NONE, 511, 15, 8'hFF, 1'b1);
		send_beat(MODE_END);
		send_beat(MODE_END);
		drain();
		write_reg(REG_THRESH, 16'hFFFF);
		write_reg(REG_WIU, 10'd0);
		send_beat(MODE_TEXT, 0, 0, "a");
		send_beat(MODE_END);
		drain();
	endtask

	// A chunk that ends by length alone; a long word spans positions 0 to 15.
	task automatic test_long_chunk();
		write_reg(REG_WIU, 10'd2);
		write_reg(REG_THRESH, 16'd1000);
		load_word(1, WordLen, "a", 0);
		drain();
		no_gaps = 1;
		for (int k = 0; k < ChunkLen + 20; k++) send_beat(MODE_TEXT, 0, 0, "a");
		no_gaps = 0;
		send_beat(MODE_END);
		drain();
	endtask

	task automatic random_loads(int count);
		int s, p, n;
		for (int k = 0; k < count; k++) begin
			s = $urandom_range(0, NumSlots - 1);
			if ($urandom_range(0, 3) == 0) begin
				// Stray character; it may finish the word only if all before it exist.
				p = $urandom_range(0, WordLen - 1);
				send_beat(MODE_LOAD, s, p, text_char(),
					(&(chr_known[s] | ~((16'h1 << p) - 1))) && $urandom_range(0, 1));
			end else begin
				n = ($urandom_range(0, 9) == 0) ? WordLen : $urandom_range(1, 4);
				load_word(s, n);
			end
		end
		drain();
	endtask

	task automatic test_random_phases();
		int wiu_val;
		for (int ph = 0; ph < 14; ph++) begin
			case ($urandom_range(0, 9))
				0: wiu_val = 512;
				1: wiu_val = 16'hFFFF;
				2: wiu_val = 0;
				default: wiu_val = $urandom_range(1, 40);
			endcase
			write_reg(REG_WIU, wiu_val);
			write_reg(REG_THRESH, ($urandom_range(0, 7) == 0) ? 16'hFFFF
				: $urandom_range(0, 30));
			random_loads($urandom_range(1, 6));
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < ((wiu_val > 40) ? 15 : 60); k++) begin
				case ($urandom_range(0, 19))
					0: send_beat(MODE_END);
					1: send_beat(MODE_NONE, $urandom_range(0, 511), $urandom_range(0, 15),
						$urandom_range(0, 255), $urandom_range(0, 1));
					default: send_beat(MODE_TEXT, $urandom, $urandom, text_char(),
						$urandom_range(0, 1));
				endcase
			end
			send_beat(MODE_END);
			no_gaps = 0;
			drain();
		end
	endtask

	// The receiver holds off while totals pile up and the input queue fills.
	task automatic test_backpressure();
		write_reg(REG_WIU, 10'd3);
		write_reg(REG_THRESH, 16'd2);
		hold_off = 300;
		no_gaps = 1;
		for (int k = 0; k < 12; k++) begin
			send_beat(MODE_TEXT, 0, 0, text_char());
			send_beat(MODE_END);
		end
		no_gaps = 0;
		drain();
	endtask

	// Result side: pops with random gaps and checks each beat.
	initial begin
		int gap;
		tally_t t;
		@(posedge arst_n);
		forever begin
			if (hold_off > 0) begin
				gap = hold_off;
				hold_off = 0;
			end else gap = draw_gap();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			if (pending_tallies.size() == 0) begin
				$display("%0t: unexpected total %0d", $time, total_matches);
				errors++;
			end else begin
				t = pending_tallies.pop_front();
				if (total_matches !== t.total || class_hit !== t.hit ||
					count_saturated !== t.sat) begin
					$display("%0t: expected total %0d hit %0b sat %0b, got %0d %0b %0b",
						$time, t.total, t.hit, t.sat, total_matches, class_hit,
						count_saturated);
					errors++;
				end
			end
		end
	end

	initial begin
		threshold = ThreshReset;
		words_searched = WiuReset;
		match_total = '0;
		match_sat = 1'b0;
		for (int s = 0; s < NumSlots; s++) begin
			word_len[s] = 0;
			chr_known[s] = '0;
		end
		clear_chunk();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_dictionary();
		test_directed();
		test_long_chunk();
		test_backpressure();
		test_random_phases();
		repeat (50) @(posedge clk);
		if (errors == 0 && pending_tallies.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

FILE: sim.f
rtl/koc_pkg.sv
rtl/koc_ram.sv
rtl/koc_front.sv
rtl/koc_back.sv
rtl/keyword_occurrence_counter.sv
rtl/koc_checker.sv
verif/tb.sv
